FILE: sv/bse_pkg.sv
// Shared constants, op codes and types of the bitmap set engine.
package bse_pkg;

  localparam int NUM_SETS      = 4;
  localparam int WORDS_PER_SET = 16;
  localparam int WORD_BITS     = 64;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WIDX_W    = $clog2(WORDS_PER_SET);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = SET_W + WIDX_W;
  localparam int DEPTH     = NUM_SETS * WORDS_PER_SET;
  localparam int CAP_LIMIT = WORDS_PER_SET * WORD_BITS;

  // Fixed field widths of the command and register ports.
  localparam int OP_W   = 4;
  localparam int SEL_W  = 2;
  localparam int ELEM_W = 12;
  localparam int CAP_W  = 11;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 4'd1;
  localparam logic [OP_W-1:0] OP_TEST    = 4'd2;
  localparam logic [OP_W-1:0] OP_UNION   = 4'd3;
  localparam logic [OP_W-1:0] OP_INTERS  = 4'd4;
  localparam logic [OP_W-1:0] OP_DIFF    = 4'd5;
  localparam logic [OP_W-1:0] OP_SYMDIFF = 4'd6;
  localparam logic [OP_W-1:0] OP_COMPL   = 4'd7;
  localparam logic [OP_W-1:0] OP_EQUAL   = 4'd8;
  localparam logic [OP_W-1:0] OP_SUBSET  = 4'd9;
  localparam logic [OP_W-1:0] OP_STRICT  = 4'd10;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd11;

  // Outputs of the word unit for one word.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;  // value to write back
    logic                 eq;    // masked words are equal
    logic                 sub;   // masked A word lies within masked B word
    logic                 hit;   // selected element bit is set in A
  } alu_res_t;

  // Set selector reduced to a valid set index.
  function automatic logic [SET_W-1:0] set_index(input logic [SEL_W-1:0] v);
    int unsigned t;
    t = 32'(v) % NUM_SETS;
    return SET_W'(t);
  endfunction

endpackage

FILE: sv/bse_word_alu.sv
// Shared word unit: set logic, capacity mask and word compare for one word.
module bse_word_alu
  import bse_pkg::*;
(
  input  logic [OP_W-1:0]      op_i,
  input  logic [WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS-1:0] y_i,
  input  logic [WIDX_W-1:0]    widx_i,
  input  logic [CAP_W-1:0]     cap_i,
  input  logic [BIT_W-1:0]     bit_i,
  output alu_res_t             res_o
);

  logic [WIDX_W+BIT_W-1:0] base;
  logic [CAP_W-1:0]        count;
  logic [WORD_BITS-1:0]    mask;
  logic [WORD_BITS-1:0]    bitm;
  logic [WORD_BITS-1:0]    xm;
  logic [WORD_BITS-1:0]    ym;

  // Valid positions of this word: the top bits up to the capacity.
  always_comb begin
    base  = {widx_i, BIT_W'(0)};
    count = cap_i - CAP_W'(base);
    if (cap_i <= CAP_W'(base)) begin
      mask = '0;
    end else if (count >= CAP_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} >> count[BIT_W-1:0]);
    end
  end

  // Element e sits at bit WORD_BITS-1 - e mod WORD_BITS.
  assign bitm = {1'b1, {(WORD_BITS-1){1'b0}}} >> bit_i;

  assign xm = x_i & mask;
  assign ym = y_i & mask;

  // Result word selected by the operation.
  always_comb begin
    case (op_i)
      OP_ADD:     res_o.word = x_i | bitm;
      OP_REMOVE:  res_o.word = x_i & ~bitm;
      OP_UNION:   res_o.word = (x_i | y_i) & mask;
      OP_INTERS:  res_o.word = (x_i & y_i) & mask;
      OP_DIFF:    res_o.word = (x_i & ~y_i) & mask;
      OP_SYMDIFF: res_o.word = (x_i ^ y_i) & mask;
      OP_COMPL:   res_o.word = ~x_i & mask;
      default:    res_o.word = x_i;
    endcase
    res_o.eq  = (xm == ym);
    res_o.sub = ((xm & ~ym) == '0);
    res_o.hit = |(x_i & bitm);
  end

endmodule

FILE: sv/bitmap_set_engine_core.sv
// Top level of the bitmap set engine: set store, sequencer and result register.
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  ---------------------------------------
//  command   start / busy                   op, set_a, set_b, dest_set, element
//  result    result_valid_o (one cycle)     status, answer
//  config    cfg_valid_i / cfg_ready_o      capacity_bits
//
// Add, remove and test hold busy for one store read and one word update.
// Set-wide ops hold busy while all WORDS_PER_SET words of a set are read:
// the word unit processes one word per cycle behind the registered store read.
// Clear, out-of-range elements and unused codes never raise busy.
// The result strobe comes in the cycle after the last busy cycle; the receiver
// cannot stall it. Reset empties every set through per-word valid bits.
module bitmap_set_engine_core
  import bse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SEL_W-1:0]  set_a_i,
  input  logic [SEL_W-1:0]  set_b_i,
  input  logic [SEL_W-1:0]  dest_set_i,
  input  logic [ELEM_W-1:0] element_i,
  output logic              result_valid_o,
  output logic              status_o,
  output logic              answer_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  capacity_bits_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CAP_W-1:0]     cap_reg_q;
  logic [CAP_W-1:0]     cap_eff;
  logic [OP_W-1:0]      op_q;
  logic [SET_W-1:0]     a_q, b_q, d_q;
  logic [ELEM_W-1:0]    elem_q;
  logic [CAP_W-1:0]     cap_q;
  logic [WIDX_W-1:0]    cnt_q, cnt_d;
  logic                 pv_q, pv_d;
  logic [WIDX_W-1:0]    pw_q, pw_d;
  logic                 eq_q, sub_q;
  logic                 strobe_q, strobe_d;
  logic                 status_q, status_d;
  logic                 answer_q, answer_d;

  logic                 accept;
  logic                 in_elem_op;
  logic                 in_out_of_range;
  logic                 in_quick;
  logic                 in_clear;
  logic                 elem_op_q;
  logic                 word_op_q;
  logic                 cmp_op_q;
  logic [WIDX_W-1:0]    rd_widx;
  logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b, wr_addr;
  logic                 wr_en;
  logic                 final_answer;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]     valid_q;
  logic [WORD_BITS-1:0] rd_a_q, rd_b_q;
  logic                 rd_va_q, rd_vb_q;
  logic [WORD_BITS-1:0] x, y;
  alu_res_t             alu_res;

  // Capacity register; values beyond the store act as the store size.
  assign cfg_ready_o = ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg_q <= CAP_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_reg_q <= capacity_bits_i;
    end
  end

  assign cap_eff = (cap_reg_q > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : cap_reg_q;

  // Request decode at acceptance.
  assign busy            = (state_q != ST_IDLE);
  assign accept          = start && !busy;
  assign in_elem_op      = (op_i <= OP_TEST);
  assign in_out_of_range = (element_i >= ELEM_W'(cap_eff));
  assign in_clear        = (op_i == OP_CLEAR);
  assign in_quick        = (in_elem_op && in_out_of_range) || (op_i >= OP_CLEAR);

  // Operation class of the request in flight.
  assign elem_op_q = (op_q <= OP_TEST);
  assign word_op_q = (op_q >= OP_UNION) && (op_q <= OP_COMPL);
  assign cmp_op_q  = (op_q >= OP_EQUAL) && (op_q <= OP_STRICT);

  // Latched request fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      a_q    <= set_index(set_a_i);
      b_q    <= set_index(set_b_i);
      d_q    <= set_index(dest_set_i);
      elem_q <= element_i;
      cap_q  <= cap_eff;
    end
  end

  // Store addresses: element ops touch one word, set-wide ops walk them all.
  assign rd_widx   = elem_op_q ? elem_q[BIT_W +: WIDX_W] : cnt_q;
  assign rd_addr_a = {a_q, rd_widx};
  assign rd_addr_b = {b_q, rd_widx};
  assign wr_addr   = elem_op_q ? {a_q, pw_q} : {d_q, pw_q};
  assign wr_en     = pv_q && (word_op_q || op_q == OP_ADD || op_q == OP_REMOVE);

  // Set store: two registered reads, one write.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= alu_res.word;
    end
  end

  // Per-word valid bits; an invalid word reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_va_q <= 1'b0;
      rd_vb_q <= 1'b0;
    end else begin
      if (state_q == ST_RUN) begin
        rd_va_q <= valid_q[rd_addr_a];
        rd_vb_q <= valid_q[rd_addr_b];
      end
      if (accept && in_clear) begin
        for (int w = 0; w < WORDS_PER_SET; w++) begin
          valid_q[{set_index(set_a_i), WIDX_W'(w)}] <= 1'b0;
        end
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign x = rd_va_q ? rd_a_q : '0;
  assign y = rd_vb_q ? rd_b_q : '0;

  // The one word unit, shared by every operation that runs on the store.
  bse_word_alu u_alu (
    .op_i   (op_q),
    .x_i    (x),
    .y_i    (y),
    .widx_i (pw_q),
    .cap_i  (cap_q),
    .bit_i  (elem_q[BIT_W-1:0]),
    .res_o  (alu_res)
  );

  // Answer including the word processed in the drain cycle.
  always_comb begin
    case (op_q)
      OP_TEST:   final_answer = alu_res.hit;
      OP_EQUAL:  final_answer = eq_q && alu_res.eq;
      OP_SUBSET: final_answer = sub_q && alu_res.sub;
      OP_STRICT: final_answer = sub_q && alu_res.sub && !(eq_q && alu_res.eq);
      default:   final_answer = 1'b0;
    endcase
  end

  // Sequencer: issue reads, process each word in the cycle after, then report.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pv_d     = 1'b0;
    pw_d     = pw_q;
    strobe_d = 1'b0;
    status_d = status_q;
    answer_d = answer_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (in_quick) begin
            strobe_d = 1'b1;
            status_d = in_elem_op && in_out_of_range;
            answer_d = 1'b0;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        pv_d = 1'b1;
        pw_d = rd_widx;
        if (elem_op_q || cnt_q == WIDX_W'(WORDS_PER_SET - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + WIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d  = ST_IDLE;
        strobe_d = 1'b1;
        status_d = 1'b0;
        answer_d = final_answer;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pv_q     <= 1'b0;
      pw_q     <= '0;
      strobe_q <= 1'b0;
      status_q <= 1'b0;
      answer_q <= 1'b0;
      eq_q     <= 1'b1;
      sub_q    <= 1'b1;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pv_q     <= pv_d;
      pw_q     <= pw_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
      answer_q <= answer_d;
      // Running compare flags over the words already processed.
      if (accept) begin
        eq_q  <= 1'b1;
        sub_q <= 1'b1;
      end else if (pv_q && cmp_op_q && state_q == ST_RUN) begin
        eq_q  <= eq_q && alu_res.eq;
        sub_q <= sub_q && alu_res.sub;
      end
    end
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign answer_o       = answer_q;

endmodule

FILE: sv/bse_checker.sv
// Port-level checks of the bitmap set engine, bound to the top level.
module bse_checker
  import bse_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [OP_W-1:0]   op_i,
  input logic              result_valid_o,
  input logic              status_o,
  input logic              answer_o
);

  // Unused codes and clear report at once with a clean result.
  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i >= OP_CLEAR) |=> (result_valid_o && !status_o && !answer_o))
    else $error("clear or unused op did not report a clean result next cycle");

  // A set-wide request keeps the engine busy while it walks the words.
  a_word_ops_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i >= OP_UNION && op_i <= OP_STRICT) |=> (busy && !result_valid_o))
    else $error("set-wide op did not start a walk");

  // Results are only reported once the engine has gone idle.
  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result reported while busy");

  // A range error never carries an answer.
  a_status_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> !answer_o)
    else $error("range error with answer set");

endmodule

bind bitmap_set_engine_core bse_checker u_bse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .answer_o       (answer_o)
);

FILE: dv/testbench.sv
// Self-checking testbench for the bitmap set engine core.
`timescale 1ns / 100ps

module testbench
  import bse_pkg::*;
();

  localparam int unsigned CAP_RESET    = 1024;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ELEM_MAX     = (1 << ELEM_W) - 1;
  localparam int unsigned SEL_MAX      = (1 << SEL_W) - 1;

  // First and last of the op codes that the engine treats as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_CLEAR + OP_W'(1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = {OP_W{1'b1}};

  // Shadow copy of the set bank that predicts every response and checks it.
  class set_bank_model;
    typedef struct {
      logic            status;
      logic            answer;
      logic [OP_W-1:0] op;
      int unsigned     seq;
    } set_response_t;

    logic [WORD_BITS-1:0] words [NUM_SETS][WORDS_PER_SET];
    int unsigned          capacity;
    set_response_t        expected_responses [$];
    int unsigned          request_count;
    int unsigned          fail_count;

    function new();
      capacity = CAP_RESET;
      request_count = 0;
      fail_count = 0;
      foreach (words[s, w]) words[s][w] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = 32'(value);
    endfunction

    function int unsigned outstanding();
      return expected_responses.size();
    endfunction

    // Valid element positions of word w under capacity cap.
    function logic [WORD_BITS-1:0] valid_mask(int unsigned w, int unsigned cap);
      int unsigned base;
      int unsigned count;
      base = w * WORD_BITS;
      if (cap <= base) return '0;
      count = cap - base;
      if (count >= WORD_BITS) return {WORD_BITS{1'b1}};
      return {WORD_BITS{1'b1}} << (WORD_BITS - count);
    endfunction

    // Apply one accepted request to the shadow bank and queue its response.
    function void note_request(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel_a,
                               logic [SEL_W-1:0] sel_b, logic [SEL_W-1:0] sel_d,
                               logic [ELEM_W-1:0] element);
      int unsigned          ia, ib, id, cap, widx;
      logic [WORD_BITS-1:0] x, y, r, m, bit_sel;
      bit                   same, contained;
      set_response_t        resp;
      ia = sel_a % NUM_SETS;
      ib = sel_b % NUM_SETS;
      id = sel_d % NUM_SETS;
      cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
      resp.status = 1'b0;
      resp.answer = 1'b0;
      resp.op = op;
      resp.seq = request_count++;
      case (op)
        OP_ADD, OP_REMOVE, OP_TEST: begin
          if (element >= cap) begin
            resp.status = 1'b1;
          end else begin
            widx = element / WORD_BITS;
            bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - 1 - element % WORD_BITS);
            if (op == OP_ADD) words[ia][widx] |= bit_sel;
            else if (op == OP_REMOVE) words[ia][widx] &= ~bit_sel;
            else resp.answer = (words[ia][widx] & bit_sel) != '0;
          end
        end
        OP_UNION, OP_INTERS, OP_DIFF, OP_SYMDIFF, OP_COMPL: begin
          // Each word is read before it is written, so aliasing is harmless.
          for (int w = 0; w < WORDS_PER_SET; w++) begin
            x = words[ia][w];
            y = words[ib][w];
            case (op)
              OP_UNION:   r = x | y;
              OP_INTERS:  r = x & y;
              OP_DIFF:    r = x & ~y;
              OP_SYMDIFF: r = x ^ y;
              default:    r = ~x;
            endcase
            words[id][w] = r & valid_mask(w, cap);
          end
        end
        OP_EQUAL, OP_SUBSET, OP_STRICT: begin
          same = 1'b1;
          contained = 1'b1;
          for (int w = 0; w < WORDS_PER_SET; w++) begin
            m = valid_mask(w, cap);
            x = words[ia][w] & m;
            y = words[ib][w] & m;
            if (x != y) same = 1'b0;
            if ((x & ~y) != '0) contained = 1'b0;
          end
          if (op == OP_EQUAL) resp.answer = same;
          else if (op == OP_SUBSET) resp.answer = contained;
          else resp.answer = contained && !same;
        end
        OP_CLEAR: begin
          for (int w = 0; w < WORDS_PER_SET; w++) words[ia][w] = '0;
        end
        default: begin
        end
      endcase
      expected_responses.push_back(resp);
    endfunction

    // Compare one observed response with the oldest prediction.
    function void check_response(logic status, logic answer);
      set_response_t resp;
      if (expected_responses.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected response status %0b answer %0b", status, answer);
        return;
      end
      resp = expected_responses.pop_front();
      if (status !== resp.status || answer !== resp.answer) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: request %0d op %0d: expected status %0b answer %0b, got %0b %0b",
                   resp.seq, resp.op, resp.status, resp.answer, status, answer);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   op_i = '0;
  logic [SEL_W-1:0]  set_a_i = '0;
  logic [SEL_W-1:0]  set_b_i = '0;
  logic [SEL_W-1:0]  dest_set_i = '0;
  logic [ELEM_W-1:0] element_i = '0;
  logic              result_valid_o;
  logic              status_o;
  logic              answer_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  capacity_bits_i = '0;

  set_bank_model model;

  bitmap_set_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .set_a_i         (set_a_i),
    .set_b_i         (set_b_i),
    .dest_set_i      (dest_set_i),
    .element_i       (element_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .answer_o        (answer_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .capacity_bits_i (capacity_bits_i)
  );

  // Free-running clock.
  always #2 clk_i = ~clk_i;

  // Response monitor: every strobe is checked against the shadow bank.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) model.check_response(status_o, answer_o);
  end

  // Present one request and hold it until the engine takes it.
  task automatic send_request(logic [OP_W-1:0] op, int unsigned sel_a, int unsigned sel_b,
                              int unsigned sel_d, int unsigned element);
    start <= 1'b1;
    op_i <= op;
    set_a_i <= sel_a[SEL_W-1:0];
    set_b_i <= sel_b[SEL_W-1:0];
    dest_set_i <= sel_d[SEL_W-1:0];
    element_i <= element[ELEM_W-1:0];
    do @(posedge clk_i); while (busy !== 1'b0);
    model.note_request(op, sel_a[SEL_W-1:0], sel_b[SEL_W-1:0], sel_d[SEL_W-1:0],
                       element[ELEM_W-1:0]);
  endtask

  // Occasionally leave the command port idle for a while.
  task automatic maybe_pause(bit allow);
    if (allow && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  // Stop issuing and wait for every outstanding response.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (model.outstanding() != 0) @(posedge clk_i);
  endtask

  // Write the capacity register; only called while the engine is idle.
  task automatic write_capacity(int unsigned value);
    cfg_valid_i <= 1'b1;
    capacity_bits_i <= value[CAP_W-1:0];
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    model.set_capacity(value[CAP_W-1:0]);
  endtask

  // Weighted op mix: adds are the most common op so the sets fill up.
  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28) return OP_ADD;
    if (r < 36) return OP_REMOVE;
    if (r < 48) return OP_TEST;
    if (r < 56) return OP_UNION;
    if (r < 62) return OP_INTERS;
    if (r < 67) return OP_DIFF;
    if (r < 72) return OP_SYMDIFF;
    if (r < 76) return OP_COMPL;
    if (r < 83) return OP_EQUAL;
    if (r < 89) return OP_SUBSET;
    if (r < 95) return OP_STRICT;
    if (r < 98) return OP_CLEAR;
    return OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
  endfunction

  // Elements cluster low for collisions, near the capacity edge, or anywhere.
  function automatic int unsigned pick_element(int unsigned cap);
    int unsigned limit;
    int unsigned r;
    limit = (cap > CAP_LIMIT) ? CAP_LIMIT : cap;
    r = $urandom_range(0, 99);
    if (limit == 0 || r < 25) return $urandom_range(0, ELEM_MAX);
    if (r < 40) return limit - 1 + $urandom_range(0, 2);
    if (r < 65) return $urandom_range(0, ((limit < 96) ? limit : 96) - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  // One configuration phase of random requests.
  task automatic run_phase(int unsigned cap, bit allow_idle);
    write_capacity(cap);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      maybe_pause(allow_idle);
      if (i == PHASE_ITEMS / 2) drain();
      send_request(pick_op(), $urandom_range(0, SEL_MAX), $urandom_range(0, SEL_MAX),
                   $urandom_range(0, SEL_MAX), pick_element(model.capacity));
    end
    drain();
  endtask

  // Safety net against a hung engine.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned cap_plan [9];
    model = new();
    cap_plan = '{0, 1, 2047, 64, 65, 1023, 1024, 0, 700};
    cap_plan[7] = $urandom_range(2, 1022);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset capacity.
    send_request(OP_ADD, 0, 3, 2, 0);
    send_request(OP_ADD, 0, 1, 1, CAP_RESET - 1);
    send_request(OP_ADD, 1, 0, 0, CAP_RESET);
    send_request(OP_ADD, 2, 1, 3, ELEM_MAX);
    send_request(OP_TEST, 0, 2, 1, 0);
    send_request(OP_TEST, 0, 2, 1, CAP_RESET - 1);
    send_request(OP_TEST, 0, 3, 3, 5);
    send_request(OP_REMOVE, 0, 1, 2, 0);
    send_request(OP_TEST, 0, 1, 2, 0);
    send_request(OP_REMOVE, 3, 0, 0, 4000);
    send_request(OP_TEST, 0, 0, 0, 2000);
    send_request(OP_ADD, 1, 0, 0, 64);
    send_request(OP_ADD, 1, 0, 0, 63);
    send_request(OP_UNION, 0, 1, 2, ELEM_MAX);
    send_request(OP_INTERS, 2, 0, 3, 0);
    // Destination doubles as the first source.
    send_request(OP_DIFF, 2, 0, 2, 0);
    send_request(OP_SYMDIFF, 0, 1, 1, 0);
    send_request(OP_COMPL, 0, 2, 0, 0);
    send_request(OP_EQUAL, 0, 0, 1, 0);
    send_request(OP_EQUAL, 0, 1, 1, 0);
    send_request(OP_SUBSET, 3, 2, 0, 0);
    send_request(OP_STRICT, 2, 2, 0, 0);
    send_request(OP_STRICT, 3, 2, 0, 0);
    send_request(OP_CLEAR, 1, 3, 3, ELEM_MAX);
    send_request(OP_SPARE_LO, 3, 3, 3, ELEM_MAX);
    send_request(OP_SPARE_HI, 2, 1, 0, 1);
    drain();

    // Random phases; the 64-bit capacity phase runs without idle gaps.
    for (int p = 0; p < 9; p++) run_phase(cap_plan[p], p != 3);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (model.fail_count == 0 && model.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
